[rtl/sos_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sos_pkg: shared types and constants of the sweep object segmenter
// Word layouts, register indexes, tracking modes and sequencer states.
// ----------------------------------------------------------------------------
package sos_pkg;

    localparam int SAMPLE_BITS      = 8;
    localparam int ANGLE_BITS       = 8;
    localparam int INDEX_BITS       = 4;
    localparam int MEAN_BITS        = 12;
    localparam int TALLY_BITS       = 8;
    localparam int COUNT_BITS       = 8;
    localparam int LIMIT_BITS       = 8;
    localparam int CFG_INDEX_BITS   = 4;
    localparam int CFG_DATA_BITS    = 8;

    // Sum of up to 255 samples of ir plus sonar.
    localparam int TOTAL_BITS       = SAMPLE_BITS + 1 + TALLY_BITS;
    // Dividend is the total times eight.
    localparam int DIVIDEND_BITS    = TOTAL_BITS + 3;
    localparam int STEP_BITS        = $clog2(DIVIDEND_BITS + 1);

    localparam logic [COUNT_BITS-1:0] MAX_OBJECT_COUNT = COUNT_BITS'(16);
    localparam logic [TALLY_BITS-1:0] TALLY_MAX        = {TALLY_BITS{1'b1}};
    localparam logic [STEP_BITS-1:0]  DIV_STEPS        = STEP_BITS'(DIVIDEND_BITS);
    localparam logic [MEAN_BITS-1:0]  MEAN_MAX         = {MEAN_BITS{1'b1}};

    localparam logic [LIMIT_BITS-1:0] NEAR_RESET       = LIMIT_BITS'(5);
    localparam logic [LIMIT_BITS-1:0] FAR_RESET        = LIMIT_BITS'(92);

    localparam logic [CFG_INDEX_BITS-1:0] REG_NEAR_LIMIT = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FAR_LIMIT  = CFG_INDEX_BITS'(1);

    typedef enum logic [1:0] {
        MODE_WAIT    = 2'd0,
        MODE_CONFIRM = 2'd1,
        MODE_TRACK   = 2'd2,
        MODE_GRACE   = 2'd3
    } sos_mode_t;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_EVAL = 2'd1,
        SEQ_DIV  = 2'd2,
        SEQ_DONE = 2'd3
    } sos_seq_t;

    typedef struct packed {
        logic                   start_sweep;
        logic [ANGLE_BITS-1:0]  angle;
        logic [SAMPLE_BITS-1:0] ir_distance;
        logic [SAMPLE_BITS-1:0] sonar_distance;
    } sos_in_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]  object_index;
        logic [ANGLE_BITS-1:0]  first_angle;
        logic [ANGLE_BITS-1:0]  last_angle;
        logic [ANGLE_BITS-1:0]  angular_width;
        logic [MEAN_BITS-1:0]   mean_distance_x16;
        logic [TALLY_BITS-1:0]  samples_used;
    } sos_out_t;

endpackage
`default_nettype wire

[rtl/sweep_object_segmenter_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sweep_object_segmenter_unit: angular sweep object segmenter
// Classifies range samples as hits, tracks objects with a four-mode machine
// and reports each finished object with its mean distance.
// ----------------------------------------------------------------------------
//  channel | ports                        | word
//  --------+------------------------------+------------------------------
//  input   | s_valid, s_ready, s_data     | sos_in_t, one angle sample
//  result  | m_valid, m_ready, m_data     | sos_out_t, one finished object
//  config  | cfg_valid, cfg_ready,        | index 0 near_limit,
//          | cfg_index, cfg_data          | index 1 far_limit
//
// A sample that ends no object is accepted and then evaluated. A sample that
// ends an object also waits for its mean, which comes from a restoring divider
// that resolves one quotient bit per cycle over 20 bits.
// Reset is synchronous and active low; it clears the machine and loads the
// limits with 5 and 92. The next sample is taken while a result still waits;
// the divider holds its result until the output register is free.
module sweep_object_segmenter_unit
    import sos_pkg::*;
(
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  sos_in_t                         s_data,
    output logic                            m_valid,
    input  wire                             m_ready,
    output sos_out_t                        m_data,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [CFG_INDEX_BITS-1:0]       cfg_index,
    input  wire  [CFG_DATA_BITS-1:0]        cfg_data
);

    sos_seq_t                seq_reg, seq_next;
    sos_mode_t               mode_reg, mode_next;
    sos_in_t                 item_reg;
    logic [LIMIT_BITS-1:0]   near_reg, far_reg;
    logic [ANGLE_BITS-1:0]   first_reg, first_next;
    logic [ANGLE_BITS-1:0]   last_reg, last_next;
    logic [TOTAL_BITS-1:0]   total_reg, total_next;
    logic [TALLY_BITS-1:0]   tally_reg, tally_next;
    logic [COUNT_BITS-1:0]   seen_reg, seen_next;
    logic [INDEX_BITS-1:0]   idx_reg;

    logic [DIVIDEND_BITS-1:0] div_reg, div_next;
    logic [TALLY_BITS-1:0]    rem_reg, rem_next;
    logic [TALLY_BITS-1:0]    divisor_reg;
    logic [STEP_BITS-1:0]     step_reg;

    logic                    m_valid_reg;
    sos_out_t                m_data_reg;

    logic                    accept;
    logic                    eval_en;
    logic                    div_en;
    logic                    out_load;
    logic                    hit;
    logic                    emit;
    logic [TOTAL_BITS-1:0]   emit_total;
    logic [TALLY_BITS-1:0]   emit_tally;
    logic [COUNT_BITS-1:0]   emit_seen;
    logic [TALLY_BITS:0]     trial;
    logic                    trial_ge;
    logic [TALLY_BITS:0]     trial_diff;
    logic [MEAN_BITS-1:0]    mean;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Sequencer next state.
    always_comb begin
        seq_next = seq_reg;
        case (seq_reg)
            SEQ_IDLE: if (s_valid) seq_next = SEQ_EVAL;
            SEQ_EVAL: seq_next = emit ? SEQ_DIV : SEQ_IDLE;
            SEQ_DIV:  if (step_reg == DIV_STEPS - STEP_BITS'(1)) seq_next = SEQ_DONE;
            SEQ_DONE: if (!m_valid_reg || m_ready) seq_next = SEQ_IDLE;
            default:  seq_next = SEQ_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_ready  = 1'b0;
        eval_en  = 1'b0;
        div_en   = 1'b0;
        out_load = 1'b0;
        case (seq_reg)
            SEQ_IDLE: s_ready  = 1'b1;
            SEQ_EVAL: eval_en  = 1'b1;
            SEQ_DIV:  div_en   = 1'b1;
            SEQ_DONE: out_load = !m_valid_reg || m_ready;
            default:  s_ready  = 1'b0;
        endcase
    end

    assign hit = (near_reg <= item_reg.ir_distance) && (item_reg.ir_distance <= far_reg)
              && (near_reg <= item_reg.sonar_distance)
              && (item_reg.sonar_distance <= far_reg);

    // Tracking step for the sample held in item_reg.
    always_comb begin
        sos_mode_t             mode_eff;
        logic                  do_acc;
        logic [TOTAL_BITS-1:0] pair_sum;

        mode_eff   = item_reg.start_sweep ? MODE_WAIT : mode_reg;
        seen_next  = item_reg.start_sweep ? '0 : seen_reg;
        total_next = item_reg.start_sweep ? '0 : total_reg;
        tally_next = item_reg.start_sweep ? '0 : tally_reg;
        first_next = first_reg;
        last_next  = last_reg;
        mode_next  = mode_eff;
        emit       = 1'b0;
        do_acc     = 1'b0;
        pair_sum   = TOTAL_BITS'(item_reg.ir_distance) + TOTAL_BITS'(item_reg.sonar_distance);
        emit_total = total_next;
        emit_tally = tally_next;
        emit_seen  = seen_next;

        case (mode_eff)
            MODE_WAIT: begin
                if (hit) begin
                    first_next = item_reg.angle;
                    total_next = '0;
                    tally_next = '0;
                    do_acc     = 1'b1;
                    mode_next  = MODE_CONFIRM;
                end
            end
            MODE_CONFIRM: begin
                if (hit) begin
                    do_acc    = 1'b1;
                    mode_next = MODE_TRACK;
                end else begin
                    total_next = '0;
                    tally_next = '0;
                    mode_next  = MODE_WAIT;
                end
            end
            MODE_TRACK: begin
                if (!hit) begin
                    last_next = item_reg.angle - ANGLE_BITS'(1);
                    mode_next = MODE_GRACE;
                end
                do_acc = 1'b1;
            end
            default: begin
                if (hit) begin
                    do_acc    = 1'b1;
                    mode_next = MODE_TRACK;
                end else begin
                    if (seen_next < MAX_OBJECT_COUNT) begin
                        emit      = 1'b1;
                        seen_next = seen_next + COUNT_BITS'(1);
                    end
                    total_next = '0;
                    tally_next = '0;
                    mode_next  = MODE_WAIT;
                end
            end
        endcase

        if (do_acc && tally_next < TALLY_MAX) begin
            total_next = total_next + pair_sum;
            tally_next = tally_next + TALLY_BITS'(1);
        end
    end

    // One restoring division step per cycle.
    always_comb begin
        trial      = {rem_reg, div_reg[DIVIDEND_BITS-1]};
        trial_ge   = trial >= {1'b0, divisor_reg};
        trial_diff = trial - {1'b0, divisor_reg};
        rem_next   = trial_ge ? trial_diff[TALLY_BITS-1:0] : trial[TALLY_BITS-1:0];
        div_next   = {div_reg[DIVIDEND_BITS-2:0], trial_ge};
    end

    always_comb begin
        if (divisor_reg == '0) begin
            mean = '0;
        end else if (|div_reg[DIVIDEND_BITS-1:MEAN_BITS]) begin
            mean = MEAN_MAX;
        end else begin
            mean = div_reg[MEAN_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg     <= SEQ_IDLE;
            mode_reg    <= MODE_WAIT;
            near_reg    <= NEAR_RESET;
            far_reg     <= FAR_RESET;
            first_reg   <= '0;
            last_reg    <= '0;
            total_reg   <= '0;
            tally_reg   <= '0;
            seen_reg    <= '0;
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
        end else begin
            seq_reg <= seq_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_NEAR_LIMIT: near_reg <= cfg_data[LIMIT_BITS-1:0];
                    REG_FAR_LIMIT:  far_reg  <= cfg_data[LIMIT_BITS-1:0];
                    default:        ;
                endcase
            end
            if (eval_en) begin
                mode_reg  <= mode_next;
                first_reg <= first_next;
                last_reg  <= last_next;
                total_reg <= total_next;
                tally_reg <= tally_next;
                seen_reg  <= seen_next;
            end
            if (eval_en) begin
                step_reg <= '0;
            end else if (div_en) begin
                step_reg <= step_reg + STEP_BITS'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        if (eval_en) begin
            div_reg     <= {emit_total, 3'b000};
            rem_reg     <= '0;
            divisor_reg <= emit_tally;
            idx_reg     <= emit_seen[INDEX_BITS-1:0];
        end else if (div_en) begin
            div_reg <= div_next;
            rem_reg <= rem_next;
        end
        if (out_load) begin
            m_data_reg.object_index      <= idx_reg;
            m_data_reg.first_angle       <= first_reg;
            m_data_reg.last_angle        <= last_reg;
            m_data_reg.angular_width     <= last_reg - first_reg;
            m_data_reg.mean_distance_x16 <= mean;
            m_data_reg.samples_used      <= divisor_reg;
        end
    end

    // An accepted word is evaluated in the very next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> seq_reg == SEQ_EVAL)
        else $error("accepted sample was not evaluated");

    // The divider never runs past its last quotient bit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg == SEQ_DIV |-> step_reg < DIV_STEPS)
        else $error("divider step count overran");

    // A new result appears only out of the finishing state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(seq_reg) == SEQ_DONE)
        else $error("result raised outside the finishing state");

    // The object count never passes its limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= MAX_OBJECT_COUNT)
        else $error("object count exceeded its limit");

    // A tracked object has been confirmed by at least two samples.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_TRACK || mode_reg == MODE_GRACE) |-> tally_reg >= TALLY_BITS'(2))
        else $error("tracked object with fewer than two samples");

endmodule
`default_nettype wire
